@@ src/ghe_pkg.sv @@
// Shared types and constants of the geohash encoder.
`default_nettype none
package ghe_pkg;

  localparam int unsigned GHE_COORD_W  = 33;
  localparam int unsigned GHE_OFFSET_W = 32;
  localparam int unsigned GHE_DIGIT_W  = 5;
  localparam int unsigned GHE_CHAR_W   = 7;
  localparam int unsigned GHE_PREC_W   = 4;

  localparam logic [GHE_PREC_W-1:0] GHE_PREC_RESET = 4'd12;

  // Legal coordinate range, both limits included.
  localparam logic signed [GHE_COORD_W-1:0] GHE_HALF_RANGE = 33'sh0_8000_0000;
  localparam logic signed [GHE_COORD_W-1:0] GHE_NEG_HALF   = -GHE_HALF_RANGE;
  localparam logic signed [GHE_COORD_W-1:0] GHE_BIAS       = 33'sh0_7FFF_FFFF;

  localparam logic [GHE_CHAR_W-1:0] GHE_ALPHABET [32] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67,
    7'h68, 7'h6a, 7'h6b, 7'h6d, 7'h6e, 7'h70, 7'h71, 7'h72,
    7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7a
  };

  typedef struct packed {
    logic [GHE_CHAR_W-1:0]  hash_char;
    logic [GHE_DIGIT_W-1:0] digit_value;
    logic                   last_char;
    logic                   out_of_range;
  } ghe_out_t;

endpackage
`default_nettype wire

@@ src/geohash_encoder_top.sv @@
// Geohash encoder top level: APB precision register, front end, queue and back end.
// A pair is registered in the queue, then its first character in the output register.
// Throughput: one character per cycle from the back-end digit sequencer while pairs
//   wait and out_ready_i is high; a pair yields max(1, min(precision, MAX_PRECISION))
//   characters; a two-entry queue takes new pairs while the back end still emits.
// Reset (rst_ni low, asynchronous): precision returns to 12, queue empty, no beat valid.
`default_nettype none
module geohash_encoder_top import ghe_pkg::*; #(
  parameter int unsigned MAX_PRECISION = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // APB configuration port
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic [2:0]                    paddr_i,
  input  wire logic [31:0]                   pwdata_i,
  output logic [31:0]                        prdata_o,
  output logic                               pready_o,
  // coordinate channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [GHE_COORD_W-1:0] lon_fixed_i,
  input  wire logic signed [GHE_COORD_W-1:0] lat_fixed_i,
  // character channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [GHE_CHAR_W-1:0]              hash_char_o,
  output logic [GHE_DIGIT_W-1:0]             digit_value_o,
  output logic                               last_char_o,
  output logic                               out_of_range_o
);

  // Index width for the digit counter; word holds every bit the deepest hash needs.
  localparam int unsigned IDX_W  = (MAX_PRECISION > 1) ? $clog2(MAX_PRECISION) : 1;
  localparam int unsigned WORD_W = GHE_DIGIT_W * MAX_PRECISION;
  localparam int unsigned ENTRY_W = 1 + IDX_W + WORD_W;

  localparam logic REG_IDX_PRECISION = 1'b0;

  logic [GHE_PREC_W-1:0] prec_q;
  logic                  cfg_wr;

  // Register index sits at paddr bit 2; low bits select bytes and are ignored.
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;
  assign prdata_o = (paddr_i[2] == REG_IDX_PRECISION) ? {28'd0, prec_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prec_q <= GHE_PREC_RESET;
    end else if (cfg_wr && (paddr_i[2] == REG_IDX_PRECISION)) begin
      prec_q <= pwdata_i[GHE_PREC_W-1:0];
    end
  end

  // Front end: classify the pair and build the interleaved bit word.
  logic               full, push, bad;
  logic [IDX_W-1:0]   last_idx;
  logic [WORD_W-1:0]  word;

  ghe_front #(
    .MAX_PRECISION(MAX_PRECISION),
    .IDX_W        (IDX_W),
    .WORD_W       (WORD_W)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .lon_fixed_i(lon_fixed_i),
    .lat_fixed_i(lat_fixed_i),
    .precision_i(prec_q),
    .full_i     (full),
    .push_o     (push),
    .bad_o      (bad),
    .last_idx_o (last_idx),
    .word_o     (word)
  );

  // Queue: hold up to two classified pairs so front and back stall independently.
  logic               head_valid, pop;
  logic [ENTRY_W-1:0] head;

  ghe_fifo #(
    .DATA_W(ENTRY_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({bad, last_idx, word}),
    .full_o      (full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_data_o (head)
  );

  // Back end: advance one digit per output beat, drop the entry after its last one.
  ghe_out_t out_beat;

  ghe_back #(
    .MAX_PRECISION(MAX_PRECISION),
    .IDX_W        (IDX_W),
    .WORD_W       (WORD_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_bad_i  (head[ENTRY_W-1]),
    .head_last_i (head[WORD_W +: IDX_W]),
    .head_word_i (head[WORD_W-1:0]),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_o       (out_beat),
    .out_ready_i (out_ready_i)
  );

  assign hash_char_o    = out_beat.hash_char;
  assign digit_value_o  = out_beat.digit_value;
  assign last_char_o    = out_beat.last_char;
  assign out_of_range_o = out_beat.out_of_range;

endmodule
`default_nettype wire

@@ src/ghe_front.sv @@
// Front end: accepts a coordinate pair, range-checks it and builds the interleaved bit word.
`default_nettype none
module ghe_front import ghe_pkg::*; #(
  parameter int unsigned MAX_PRECISION = 12,
  parameter int unsigned IDX_W         = 4,
  parameter int unsigned WORD_W        = 60
) (
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [GHE_COORD_W-1:0] lon_fixed_i,
  input  wire logic signed [GHE_COORD_W-1:0] lat_fixed_i,
  input  wire logic [GHE_PREC_W-1:0]         precision_i,
  input  wire logic                          full_i,
  output logic                               push_o,
  output logic                               bad_o,
  output logic [IDX_W-1:0]                   last_idx_o,
  output logic [WORD_W-1:0]                  word_o
);

  logic signed [GHE_COORD_W:0] lon_sum, lat_sum;
  logic [GHE_OFFSET_W-1:0]     lon_off, lat_off;
  logic [GHE_PREC_W-1:0]       prec_eff;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  assign bad_o = (lon_fixed_i < GHE_NEG_HALF) || (lon_fixed_i > GHE_HALF_RANGE) ||
                 (lat_fixed_i < GHE_NEG_HALF) || (lat_fixed_i > GHE_HALF_RANGE);

  // Strict "above midpoint" equals the plain binary digits of (offset - 1), floored at 0.
  assign lon_sum = {lon_fixed_i[GHE_COORD_W-1], lon_fixed_i} + {GHE_BIAS[GHE_COORD_W-1], GHE_BIAS};
  assign lat_sum = {lat_fixed_i[GHE_COORD_W-1], lat_fixed_i} + {GHE_BIAS[GHE_COORD_W-1], GHE_BIAS};
  assign lon_off = (lon_fixed_i == GHE_NEG_HALF) ? '0 : lon_sum[GHE_OFFSET_W-1:0];
  assign lat_off = (lat_fixed_i == GHE_NEG_HALF) ? '0 : lat_sum[GHE_OFFSET_W-1:0];

  // Interleave MSB first, longitude on even positions.
  for (genvar gj = 0; gj < WORD_W; gj++) begin : g_ilv
    if (gj % 2 == 0) begin : g_lon
      assign word_o[WORD_W-1-gj] = lon_off[GHE_OFFSET_W-1-gj/2];
    end else begin : g_lat
      assign word_o[WORD_W-1-gj] = lat_off[GHE_OFFSET_W-1-gj/2];
    end
  end

  always_comb begin
    if (precision_i == '0) begin
      prec_eff = 4'd1;
    end else if (precision_i > GHE_PREC_W'(MAX_PRECISION)) begin
      prec_eff = GHE_PREC_W'(MAX_PRECISION);
    end else begin
      prec_eff = precision_i;
    end
  end

  assign last_idx_o = IDX_W'(prec_eff - 4'd1);

endmodule
`default_nettype wire

@@ src/ghe_fifo.sv @@
// Two-entry queue between front and back ends.
`default_nettype none
module ghe_fifo #(
  parameter int unsigned DATA_W = 65
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   head_valid_o,
  output logic [DATA_W-1:0]      head_data_o
);

  localparam int unsigned DEPTH = 2;

  logic [DATA_W-1:0] slot_q [DEPTH];
  logic              wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]        cnt_q, cnt_d;

  assign full_o       = (cnt_q == 2'(DEPTH));
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

@@ src/ghe_back.sv @@
// Back end: steps through the head entry's digits, one beat per cycle unless stalled.
`default_nettype none
module ghe_back import ghe_pkg::*; #(
  parameter int unsigned MAX_PRECISION = 12,
  parameter int unsigned IDX_W         = 4,
  parameter int unsigned WORD_W        = 60
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              head_valid_i,
  input  wire logic              head_bad_i,
  input  wire logic [IDX_W-1:0]  head_last_i,
  input  wire logic [WORD_W-1:0] head_word_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  output ghe_out_t               out_o,
  input  wire logic              out_ready_i
);

  logic [GHE_DIGIT_W-1:0] digits [MAX_PRECISION];
  logic [GHE_DIGIT_W-1:0] digit;
  logic [IDX_W-1:0]       k_q, k_d;
  logic                   ov_q, ov_d;
  ghe_out_t               out_q, out_d;
  logic                   adv, is_last;

  for (genvar gi = 0; gi < MAX_PRECISION; gi++) begin : g_dig
    assign digits[gi] = head_word_i[WORD_W-1-GHE_DIGIT_W*gi -: GHE_DIGIT_W];
  end

  assign digit   = digits[k_q];
  assign is_last = (k_q == head_last_i);
  assign adv     = head_valid_i && (!ov_q || out_ready_i);
  assign pop_o   = adv && is_last;

  always_comb begin
    k_d   = k_q;
    ov_d  = ov_q;
    out_d = out_q;
    if (adv) begin
      ov_d               = 1'b1;
      k_d                = is_last ? '0 : k_q + IDX_W'(1);
      out_d.hash_char    = head_bad_i ? '0 : GHE_ALPHABET[digit];
      out_d.digit_value  = head_bad_i ? '0 : digit;
      out_d.last_char    = is_last;
      out_d.out_of_range = head_bad_i;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      k_q  <= k_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = ov_q;
  assign out_o       = out_q;

  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (k_q == '0))
    else $error("digit index not cleared after last character");

  a_index_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (k_q <= head_last_i))
    else $error("digit index past last character of entry");

  a_entry_kept_midway: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_q != '0) |-> head_valid_i)
    else $error("entry left the queue before its last character");

  a_error_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.out_of_range) |-> (out_o.hash_char == '0 && out_o.digit_value == '0))
    else $error("out of range beat carries a nonzero character");

endmodule
`default_nettype wire

@@ tb/tb_geohash_encoder_top.sv @@
// Self-checking testbench for the geohash encoder: APB precision, coordinate and character beats.
`timescale 1ns / 100ps
module tb_geohash_encoder_top;
  import ghe_pkg::*;

  localparam int unsigned MAX_PRECISION = 12;
  localparam logic [2:0]  REG_PRECISION = 3'd0;   // byte address of the precision register
  localparam longint      HALF          = longint'(1) << 31;
  localparam int unsigned N_PHASES      = 8;
  localparam int unsigned PHASE_ITEMS   = 40;
  localparam int unsigned HOLD_CYCLES   = 160;    // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 4;      // pause before a register write
  localparam int unsigned DRAIN_CYCLES  = 16;     // quiet time after the last character
  localparam int unsigned STALL_LIMIT   = 2000;   // cycles without any beat before giving up

  // One row of directed stimulus. Rows with fixed_exp set carry the character, digit
  // and range flag that every beat of the pair must show; the others go to the predictor.
  typedef struct packed {
    logic signed [GHE_COORD_W-1:0] lon;
    logic signed [GHE_COORD_W-1:0] lat;
    logic                          fixed_exp;
    logic [GHE_CHAR_W-1:0]         ch;
    logic [GHE_DIGIT_W-1:0]        dig;
    logic                          oor;
  } pair_row_t;

  localparam pair_row_t DIRECTED_ROWS [16] = '{
    // both at the lower limit: every bisection goes low, all '0'
    '{GHE_NEG_HALF, GHE_NEG_HALF, 1'b1, 7'h30, 5'd0, 1'b0},
    // both at the upper limit: every bisection goes high, all 'z'
    '{GHE_HALF_RANGE, GHE_HALF_RANGE, 1'b1, 7'h7a, 5'd31, 1'b0},
    '{33'sd0, 33'sd0, 1'b0, 7'h0, 5'd0, 1'b0},
    // one past either limit on either axis flags the whole pair
    '{GHE_HALF_RANGE + 33'sd1, 33'sd0, 1'b1, 7'h0, 5'd0, 1'b1},
    '{33'sd0, GHE_HALF_RANGE + 33'sd1, 1'b1, 7'h0, 5'd0, 1'b1},
    '{GHE_NEG_HALF - 33'sd1, 33'sd0, 1'b1, 7'h0, 5'd0, 1'b1},
    '{33'sd0, GHE_NEG_HALF - 33'sd1, 1'b1, 7'h0, 5'd0, 1'b1},
    // field extremes, all out of range
    '{33'sh0_FFFF_FFFF, 33'sh1_0000_0000, 1'b1, 7'h0, 5'd0, 1'b1},
    '{33'sh1_0000_0000, 33'sh1_0000_0000, 1'b1, 7'h0, 5'd0, 1'b1},
    '{33'sh0_FFFF_FFFF, 33'sh0_FFFF_FFFF, 1'b1, 7'h0, 5'd0, 1'b1},
    // mixed limits, values next to the midpoint and other legal patterns
    '{GHE_HALF_RANGE, GHE_NEG_HALF, 1'b0, 7'h0, 5'd0, 1'b0},
    '{GHE_NEG_HALF, GHE_HALF_RANGE, 1'b0, 7'h0, 5'd0, 1'b0},
    '{33'sd1, -33'sd1, 1'b0, 7'h0, 5'd0, 1'b0},
    '{-33'sd1, 33'sd1, 1'b0, 7'h0, 5'd0, 1'b0},
    '{33'sh0_5555_5555, 33'sh1_AAAA_AAAA, 1'b0, 7'h0, 5'd0, 1'b0},
    '{GHE_BIAS, -GHE_BIAS, 1'b0, 7'h0, 5'd0, 1'b0}
  };

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel_i;
  logic                          penable_i;
  logic                          pwrite_i;
  logic [2:0]                    paddr_i;
  logic [31:0]                   pwdata_i;
  logic [31:0]                   prdata_o;
  logic                          pready_o;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic signed [GHE_COORD_W-1:0] lon_fixed_i;
  logic signed [GHE_COORD_W-1:0] lat_fixed_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [GHE_CHAR_W-1:0]         hash_char_o;
  logic [GHE_DIGIT_W-1:0]        digit_value_o;
  logic                          last_char_o;
  logic                          out_of_range_o;

  string        gh_alphabet = "0123456789bcdefghjkmnpqrstuvwxyz";
  ghe_out_t     hash_q[$];        // characters still owed by the block, oldest first
  logic [3:0]   prec_reg;         // our copy of the precision register
  int unsigned  mismatch_cnt;
  int unsigned  quiet_cycles;
  bit           idle_on;          // random gaps on both channels when set
  bit           hold_req;         // ask the receiver for one long hold-off

  geohash_encoder_top #(
    .MAX_PRECISION(MAX_PRECISION)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel_i        (psel_i),
    .penable_i     (penable_i),
    .pwrite_i      (pwrite_i),
    .paddr_i       (paddr_i),
    .pwdata_i      (pwdata_i),
    .prdata_o      (prdata_o),
    .pready_o      (pready_o),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .lon_fixed_i   (lon_fixed_i),
    .lat_fixed_i   (lat_fixed_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hash_char_o   (hash_char_o),
    .digit_value_o (digit_value_o),
    .last_char_o   (last_char_o),
    .out_of_range_o(out_of_range_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $time);
    mismatch_cnt++;
  endtask

  // Characters per pair: zero counts as one, anything past the maximum saturates.
  function automatic int chars_per_pair();
    if (prec_reg == '0) return 1;
    if (prec_reg > MAX_PRECISION) return MAX_PRECISION;
    return int'(prec_reg);
  endfunction

  // Bisect both axes alternately, longitude first, and queue every character the
  // pair must produce. Rows with a fixed expectation override character, digit and flag.
  function automatic void queue_hash(input pair_row_t row);
    longint   coord [2];
    longint   lo [2];
    longint   hi [2];
    longint   mid;
    int       n;
    int       axis;
    bit       bad;
    bit       up;
    logic [4:0] dig;
    byte      ch;
    ghe_out_t beat;
    coord[0] = row.lon;
    coord[1] = row.lat;
    n = chars_per_pair();
    bad = coord[0] < -HALF || coord[0] > HALF || coord[1] < -HALF || coord[1] > HALF;
    lo = '{-HALF, -HALF};
    hi = '{HALF, HALF};
    axis = 0;
    for (int k = 0; k < n; k++) begin
      dig = '0;
      for (int b = 0; b < 5; b++) begin
        mid = lo[axis] + (hi[axis] - lo[axis]) / 2;
        up  = coord[axis] > mid;
        dig = {dig[3:0], up};
        if (up) lo[axis] = mid;
        else    hi[axis] = mid;
        axis ^= 1;
      end
      ch = gh_alphabet[dig];
      if (row.fixed_exp) begin
        beat.hash_char    = row.ch;
        beat.digit_value  = row.dig;
        beat.out_of_range = row.oor;
      end else begin
        beat.hash_char    = bad ? '0 : ch[6:0];
        beat.digit_value  = bad ? '0 : dig;
        beat.out_of_range = bad;
      end
      beat.last_char = (k == n - 1);
      hash_q = {hash_q, beat};
    end
  endfunction

  // Gap length: mostly none or short, a few long; none at all while idling is off.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random coordinate: mostly legal, some at or just beside the limits, some anywhere in 33 bits.
  function automatic logic signed [GHE_COORD_W-1:0] rand_coord();
    int unsigned r;
    longint      v;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      v = longint'($urandom) - HALF;
    end else if (r < 88) begin
      v = ($urandom_range(0, 1) ? HALF : -HALF) + longint'($urandom_range(0, 2)) - 1;
    end else begin
      v = {$urandom_range(0, 1), $urandom};
    end
    return v[GHE_COORD_W-1:0];
  endfunction

  // Offer one pair, entered and left at a falling edge. Valid stays high on return so a
  // back-to-back pair needs no drop; the caller lowers it when the burst ends.
  task automatic send_pair(input pair_row_t row);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    lon_fixed_i = row.lon;
    lat_fixed_i = row.lat;
    in_valid_i  = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    queue_hash(row);
    @(negedge clk_i);
  endtask

  // Write the precision register, read it back, and update our copy.
  task automatic write_precision(input logic [3:0] value);
    psel_i    = 1'b1;
    penable_i = 1'b0;
    pwrite_i  = 1'b1;
    paddr_i   = REG_PRECISION;
    pwdata_i  = {28'd0, value};
    @(negedge clk_i);
    penable_i = 1'b1;
    do @(posedge clk_i); while (!pready_o);
    @(negedge clk_i);
    penable_i = 1'b0;
    pwrite_i  = 1'b0;
    @(negedge clk_i);
    penable_i = 1'b1;
    do @(posedge clk_i); while (!pready_o);
    if (prdata_o !== {28'd0, value}) report_mismatch("precision readback", prdata_o, value);
    @(negedge clk_i);
    psel_i    = 1'b0;
    penable_i = 1'b0;
    prec_reg  = value;
  endtask

  task automatic wait_drained();
    while (hash_q.size() != 0) @(negedge clk_i);
  endtask

  // Main stimulus: reset, directed rows at the reset precision, then random phases.
  initial begin
    logic [3:0] phase_prec [N_PHASES];
    pair_row_t  row;
    rst_ni       = 1'b0;
    psel_i       = 1'b0;
    penable_i    = 1'b0;
    pwrite_i     = 1'b0;
    paddr_i      = '0;
    pwdata_i     = '0;
    in_valid_i   = 1'b0;
    lon_fixed_i  = '0;
    lat_fixed_i  = '0;
    prec_reg     = GHE_PREC_RESET;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    // Hold reset, then release it away from the rising edge.
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed rows run at the reset precision, so twelve characters each.
    foreach (DIRECTED_ROWS[i]) send_pair(DIRECTED_ROWS[i]);
    in_valid_i = 1'b0;

    // Precision per phase: the shortest, zero, the top code, just past the maximum,
    // the maximum, then random codes.
    phase_prec = '{4'd1, 4'd0, 4'd15, 4'd13, 4'd12, 4'd0, 4'd0, 4'd0};
    for (int p = 5; p < N_PHASES; p++) phase_prec[p] = 4'($urandom_range(0, 15));

    for (int p = 0; p < N_PHASES; p++) begin
      // Pause the sender until every character is back, then let the pipe settle.
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clk_i);
      write_precision(phase_prec[p]);
      // Run one phase without gaps; stall the receiver for a long stretch in another
      // so the queue fills and the coordinate channel backs up.
      idle_on = (p != 3);
      if (p == 4) hold_req = 1'b1;
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        row           = '0;
        row.lon       = rand_coord();
        row.lat       = rand_coord();
        row.fixed_exp = 1'b0;
        send_pair(row);
      end
      in_valid_i = 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (hash_q.size() != 0) report_mismatch("characters never delivered", hash_q.size(), 0);
    if (mismatch_cnt == 0) begin
      $display("tb_geohash_encoder_top OK");
    end else begin
      $display("tb_geohash_encoder_top NOT OK");
    end
    $finish;
  end

  // Receiver: ready high most of the time, random stalls, and one long hold-off on request.
  initial begin
    int unsigned stall_cnt;
    int unsigned hold_cnt;
    bit          hold_done;
    out_ready_i = 1'b0;
    stall_cnt   = 0;
    hold_cnt    = 0;
    hold_done   = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_cnt  = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        out_ready_i = 1'b0;
        hold_cnt--;
      end else if (stall_cnt > 0) begin
        out_ready_i = 1'b0;
        stall_cnt--;
      end else begin
        out_ready_i = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_cnt = pick_gap();
      end
    end
  end

  // Check every character beat against the oldest expectation, field by field.
  always @(posedge clk_i) begin
    ghe_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (hash_q.size() == 0) begin
        report_mismatch("character beat with nothing pending", hash_char_o, 0);
      end else begin
        want = hash_q.pop_front();
        if (hash_char_o !== want.hash_char)
          report_mismatch("hash_char", hash_char_o, want.hash_char);
        if (digit_value_o !== want.digit_value)
          report_mismatch("digit_value", digit_value_o, want.digit_value);
        if (last_char_o !== want.last_char)
          report_mismatch("last_char", last_char_o, want.last_char);
        if (out_of_range_o !== want.out_of_range)
          report_mismatch("out_of_range", out_of_range_o, want.out_of_range);
      end
    end
  end

  // Watchdog: end the run when no beat moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_geohash_encoder_top NOT OK");
        $finish;
      end
    end
  end

endmodule

@@ files.f @@
src/ghe_pkg.sv
src/ghe_front.sv
src/ghe_fifo.sv
src/ghe_back.sv
src/geohash_encoder_top.sv
tb/tb_geohash_encoder_top.sv
